### sv/vrfh_pkg.sv
// Shared types and constants of the voxel ray first-hit block.
package vrfh_pkg;

    localparam int DIR_W  = 16;
    localparam int POS_W  = 32;
    localparam int DIST_W = 32;
    localparam int IDX_W  = 6;
    localparam int DIV_W  = 31;
    localparam int T_W    = 49;
    localparam logic [T_W-1:0] T_INF = '1;

    typedef enum logic
    {
        OP_WRITE = 1'b0,
        OP_CAST  = 1'b1
    } op_t;

    typedef struct packed
    {
        op_t                          op;
        logic                         solid;
        logic [2:0][POS_W-1:0]        cur;
        logic [2:0][DIR_W-1:0]        dir;
        logic [2:0][15:0]             frac;
        logic [DIST_W-1:0]            maxd;
    } item_t;

    typedef struct packed
    {
        logic clearing;
        logic result_loaded;
    } back_status_t;

endpackage

### sv/voxel_ray_first_hit.sv
// Top level of the voxel ray first-hit block: front end, item queue and back end.
//
// Usage: input transactions enter through push/full. A write (operation 0) sets
// one voxel of the GRID^3 occupancy grid and gives no result; an index at or
// beyond GRID is ignored. A cast (operation 1) walks a 3D DDA from the origin
// and gives exactly one result transaction on the empty/pop side: the first
// solid voxel and its boundary distance, or no hit with max_distance.
// An accepted transaction waits in the item queue until the back end is idle.
// A write is done in the back end as it is taken from the queue. A cast starts,
// runs the bit-serial boundary and delta divisions, tests each voxel with one
// occupancy memory read and one test, and then loads the result register once
// the receiver has room for it. The time a cast takes is set mostly by the walk
// through the single-read occupancy memory.
// Two queued items let the caller push while a cast is being walked.
// After reset all 2^(3*ceil(log2 GRID)) voxels (262144 for GRID 64) are cleared,
// one voxel per cycle; full stays high while this runs.
// When the receiver does not pop, the result is held and the back end stops
// once its next result is ready; the queue then fills and full rises.
module voxel_ray_first_hit #(
    parameter int GRID       = 64,
    parameter int STEP_LIMIT = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        operation,
    input  logic [5:0]  voxel_x,
    input  logic [5:0]  voxel_y,
    input  logic [5:0]  voxel_z,
    input  logic        voxel_solid,
    input  logic [31:0] origin_x,
    input  logic [31:0] origin_y,
    input  logic [31:0] origin_z,
    input  logic [15:0] dir_x,
    input  logic [15:0] dir_y,
    input  logic [15:0] dir_z,
    input  logic [31:0] max_distance,
    output logic        empty,
    input  logic        pop,
    output logic        hit,
    output logic [5:0]  hit_x,
    output logic [5:0]  hit_y,
    output logic [5:0]  hit_z,
    output logic [31:0] hit_distance
);
    import vrfh_pkg::*;

    item_t        f_item;
    item_t        q_item;
    logic         q_full;
    logic         q_empty;
    logic         q_push;
    logic         q_pop;
    back_status_t bk_st;

    assign full   = q_full || bk_st.clearing;
    assign q_push = push && !full;

    vrfh_front u_front (
        .operation   (operation),
        .voxel_x     (voxel_x),
        .voxel_y     (voxel_y),
        .voxel_z     (voxel_z),
        .voxel_solid (voxel_solid),
        .origin_x    (origin_x),
        .origin_y    (origin_y),
        .origin_z    (origin_z),
        .dir_x       (dir_x),
        .dir_y       (dir_y),
        .dir_z       (dir_z),
        .max_distance(max_distance),
        .item        (f_item)
    );

    vrfh_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (q_push),
        .wdata  (f_item),
        .rd     (q_pop),
        .rdata  (q_item),
        .q_full (q_full),
        .q_empty(q_empty)
    );

    vrfh_back #(
        .GRID      (GRID),
        .STEP_LIMIT(STEP_LIMIT)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_item      (q_item),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .pop         (pop),
        .empty       (empty),
        .hit         (hit),
        .hit_x       (hit_x),
        .hit_y       (hit_y),
        .hit_z       (hit_z),
        .hit_distance(hit_distance),
        .status      (bk_st)
    );

    a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        bk_st.clearing |-> full)
    else $error("input accepted while the grid is being cleared");

    a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
    else $error("back end took an item from an empty queue");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |=> !q_empty)
    else $error("accepted transaction did not reach the queue");

    a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        bk_st.result_loaded |=> !empty)
    else $error("result was not placed in the output register");
endmodule

### sv/vrfh_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module vrfh_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### sv/vrfh_front.sv
// Front end: takes input transactions and turns them into queue entries.
module vrfh_front (
    input  logic               operation,
    input  logic [5:0]         voxel_x,
    input  logic [5:0]         voxel_y,
    input  logic [5:0]         voxel_z,
    input  logic               voxel_solid,
    input  logic [31:0]        origin_x,
    input  logic [31:0]        origin_y,
    input  logic [31:0]        origin_z,
    input  logic [15:0]        dir_x,
    input  logic [15:0]        dir_y,
    input  logic [15:0]        dir_z,
    input  logic [31:0]        max_distance,
    output vrfh_pkg::item_t    item
);
    import vrfh_pkg::*;

    logic [2:0][POS_W-1:0] org;
    logic [2:0][IDX_W-1:0] vox;

    assign org = {origin_z, origin_y, origin_x};
    assign vox = {voxel_z, voxel_y, voxel_x};

    always_comb
    begin
        item.op    = op_t'(operation);
        item.solid = voxel_solid;
        item.dir   = {dir_z, dir_y, dir_x};
        item.maxd  = max_distance;
        for (int a = 0; a < 3; a++)
        begin
            item.frac[a] = org[a][15:0];
            // A cast starts in the voxel that holds its origin (floor of Q16.16).
            if (operation == OP_CAST)
            begin
                item.cur[a] = {{16{org[a][31]}}, org[a][31:16]};
            end
            else
            begin
                item.cur[a] = {{(POS_W-IDX_W){1'b0}}, vox[a]};
            end
        end
    end
endmodule

### sv/vrfh_queue.sv
// Two-entry queue of classified items between the front and back ends.
module vrfh_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr,
    input  vrfh_pkg::item_t wdata,
    input  logic            rd,
    output vrfh_pkg::item_t rdata,
    output logic            q_full,
    output logic            q_empty
);
    import vrfh_pkg::*;

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);

    item_t           slot_reg [DEPTH];
    logic [PW-1:0]   wptr_reg;
    logic [PW-1:0]   rptr_reg;
    logic [PW:0]     count_reg;

    assign q_full  = (count_reg == (PW+1)'(DEPTH));
    assign q_empty = (count_reg == '0);
    assign rdata   = slot_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            slot_reg[wptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (wr)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (rd)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (wr && !rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd && !wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end
endmodule

### sv/vrfh_back.sv
// Back end: grid clearing, voxel writes, ray setup divisions and the DDA walk.
module vrfh_back #(
    parameter int GRID       = 64,
    parameter int STEP_LIMIT = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  vrfh_pkg::item_t             q_item,
    input  logic                        q_empty,
    output logic                        q_pop,
    input  logic                        pop,
    output logic                        empty,
    output logic                        hit,
    output logic [5:0]                  hit_x,
    output logic [5:0]                  hit_y,
    output logic [5:0]                  hit_z,
    output logic [31:0]                 hit_distance,
    output vrfh_pkg::back_status_t      status
);
    import vrfh_pkg::*;

    localparam int AW     = $clog2(GRID);
    localparam int ADDR_W = 3 * AW;
    localparam int DEPTH  = 2 ** ADDR_W;
    localparam int SW     = $clog2(STEP_LIMIT + 1);
    localparam int CW     = $clog2(DIV_W + 1);

    typedef enum logic [2:0]
    {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_WALK,
        S_TEST,
        S_DONE
    } state_t;

    state_t                  state_reg;
    logic [ADDR_W-1:0]       clr_addr_reg;
    logic [CW-1:0]           div_cnt_reg;
    logic [SW-1:0]           step_cnt_reg;
    logic [2:0][POS_W-1:0]   cur_reg;
    logic [2:0]              neg_reg;
    logic [2:0]              zero_reg;
    logic [2:0][15:0]        ad_reg;
    logic [5:0][15:0]        rem_reg;
    logic [5:0][DIV_W-1:0]   quo_reg;
    logic [2:0][T_W-1:0]     tmax_reg;
    logic [2:0][T_W-1:0]     tdel_reg;
    logic [T_W-1:0]          t_reg;
    logic [DIST_W-1:0]       maxd_reg;
    logic                    inb_reg;
    logic                    res_hit_reg;
    logic [2:0][IDX_W-1:0]   res_idx_reg;
    logic [DIST_W-1:0]       res_dist_reg;
    logic                    out_valid_reg;
    logic                    out_hit_reg;
    logic [2:0][IDX_W-1:0]   out_idx_reg;
    logic [DIST_W-1:0]       out_dist_reg;

    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_waddr;
    logic                    ram_wdata;
    logic [ADDR_W-1:0]       ram_raddr;
    logic                    ram_rdata;

    logic [5:0][15:0]        rem_step;
    logic [5:0][DIV_W-1:0]   quo_step;
    logic [T_W-1:0]          t_min;
    logic [1:0]              ax;
    logic                    out_free;
    logic                    wr_inb;
    logic                    walk_inb;

    function automatic logic in_grid(input logic [2:0][POS_W-1:0] c);
        logic ok;
        ok = 1'b1;
        for (int a = 0; a < 3; a++)
        begin
            if ($signed(c[a]) < 0 || $signed(c[a]) >= $signed(POS_W'(GRID)))
            begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    function automatic logic [ADDR_W-1:0] addr_of(input logic [2:0][POS_W-1:0] c);
        return {c[0][AW-1:0], c[1][AW-1:0], c[2][AW-1:0]};
    endfunction

    vrfh_ram #(
        .WIDTH(1),
        .DEPTH(DEPTH)
    ) u_grid (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign out_free = !out_valid_reg || pop;
    assign q_pop    = (state_reg == S_IDLE) && !q_empty;
    assign wr_inb   = in_grid(q_item.cur);
    assign walk_inb = in_grid(cur_reg);

    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = 1'b0;
        end
        else
        begin
            ram_we    = q_pop && (q_item.op == OP_WRITE) && wr_inb;
            ram_waddr = addr_of(q_item.cur);
            ram_wdata = q_item.solid;
        end
        ram_raddr = addr_of(cur_reg);
    end

    // One restoring-division step per lane; lanes 0-2 give first boundaries,
    // lanes 3-5 give the per-axis deltas.
    always_comb
    begin
        for (int l = 0; l < 6; l++)
        begin
            logic [16:0] sh;
            logic [16:0] dv;
            sh = {rem_reg[l], quo_reg[l][DIV_W-1]};
            dv = {1'b0, ad_reg[l % 3]};
            if (sh >= dv)
            begin
                rem_step[l] = 16'(sh - dv);
                quo_step[l] = {quo_reg[l][DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_step[l] = sh[15:0];
                quo_step[l] = {quo_reg[l][DIV_W-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        t_min = tmax_reg[0];
        if (tmax_reg[1] < t_min)
        begin
            t_min = tmax_reg[1];
        end
        if (tmax_reg[2] < t_min)
        begin
            t_min = tmax_reg[2];
        end
        // Ties go to z; a tie between x and y alone goes to y.
        if (tmax_reg[0] < tmax_reg[1])
        begin
            ax = (tmax_reg[0] < tmax_reg[2]) ? 2'd0 : 2'd2;
        end
        else
        begin
            ax = (tmax_reg[1] < tmax_reg[2]) ? 2'd1 : 2'd2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            div_cnt_reg   <= '0;
            step_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == '1)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (q_pop && q_item.op == OP_CAST)
                    begin
                        cur_reg     <= q_item.cur;
                        maxd_reg    <= q_item.maxd;
                        div_cnt_reg <= '0;
                        for (int a = 0; a < 3; a++)
                        begin
                            logic [15:0] d;
                            logic [16:0] num;
                            d             = q_item.dir[a];
                            neg_reg[a]   <= d[15];
                            zero_reg[a]  <= (d == '0);
                            ad_reg[a]    <= d[15] ? 16'(-d) : d;
                            num           = d[15] ? {1'b0, q_item.frac[a]}
                                                  : 17'h10000 - {1'b0, q_item.frac[a]};
                            rem_reg[a]   <= '0;
                            rem_reg[a+3] <= '0;
                            quo_reg[a]   <= {num, 14'b0};
                            quo_reg[a+3] <= DIV_W'(1) << 30;
                        end
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    rem_reg     <= rem_step;
                    quo_reg     <= quo_step;
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (div_cnt_reg == CW'(DIV_W - 1))
                    begin
                        for (int a = 0; a < 3; a++)
                        begin
                            tmax_reg[a] <= zero_reg[a] ? T_INF : T_W'(quo_step[a]);
                            tdel_reg[a] <= zero_reg[a] ? T_INF : T_W'(quo_step[a+3]);
                        end
                        step_cnt_reg <= '0;
                        state_reg    <= S_WALK;
                    end
                end
                S_WALK:
                begin
                    if (step_cnt_reg == SW'(STEP_LIMIT) || t_min > T_W'(maxd_reg))
                    begin
                        res_hit_reg  <= 1'b0;
                        res_idx_reg  <= '0;
                        res_dist_reg <= maxd_reg;
                        state_reg    <= S_DONE;
                    end
                    else
                    begin
                        t_reg     <= t_min;
                        inb_reg   <= walk_inb;
                        state_reg <= S_TEST;
                    end
                end
                S_TEST:
                begin
                    if (inb_reg && ram_rdata)
                    begin
                        res_hit_reg <= 1'b1;
                        for (int a = 0; a < 3; a++)
                        begin
                            res_idx_reg[a] <= cur_reg[a][IDX_W-1:0];
                        end
                        res_dist_reg <= t_reg[DIST_W-1:0];
                        state_reg    <= S_DONE;
                    end
                    else
                    begin
                        cur_reg[ax]  <= neg_reg[ax] ? cur_reg[ax] - 1'b1
                                                    : cur_reg[ax] + 1'b1;
                        tmax_reg[ax] <= tmax_reg[ax] + tdel_reg[ax];
                        step_cnt_reg <= step_cnt_reg + 1'b1;
                        state_reg    <= S_WALK;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_hit_reg   <= res_hit_reg;
                        out_idx_reg   <= res_idx_reg;
                        out_dist_reg  <= res_dist_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign empty                = !out_valid_reg;
    assign hit                  = out_hit_reg;
    assign hit_x                = out_idx_reg[0];
    assign hit_y                = out_idx_reg[1];
    assign hit_z                = out_idx_reg[2];
    assign hit_distance         = out_dist_reg;
    assign status.clearing      = (state_reg == S_CLEAR);
    assign status.result_loaded = (state_reg == S_DONE) && out_free;
endmodule
